[design/tsa_pkg.sv]
// shared types, codes and constants of the trip statistics accumulator
package tsa_pkg;

  localparam int unsigned AvgScale    = 36;
  localparam int unsigned MetresPerKm = 1000;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;
  localparam logic [7:0]  ClimbStepRst = 8'd5;
  localparam logic [9:0]  JumpLimitRst = 10'd50;

  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_CLEAR     = 3'd1,
    KIND_NEW_TRIP  = 3'd2,
    KIND_PAUSE_ON  = 3'd3,
    KIND_PAUSE_OFF = 3'd4,
    KIND_RESET_DAY = 3'd5,
    KIND_SET_TOTAL = 3'd6,
    KIND_NONE      = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    CFG_COUNT_TOTAL = 2'd0,
    CFG_CLIMB_STEP  = 2'd1,
    CFG_JUMP_LIMIT  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        odometer_m;
    logic [7:0]         speed_kmh;
    logic signed [15:0] altitude;
    logic [15:0]        set_km;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        trip_distance;
    logic [7:0]         top_speed;
    logic [31:0]        moving_time;
    logic [31:0]        standing_time;
    logic signed [15:0] highest_alt;
    logic signed [15:0] lowest_alt;
    logic [31:0]        climbed;
    logic [31:0]        dropped;
    logic [15:0]        avg_moving;
    logic [15:0]        avg_overall;
    logic [31:0]        day_distance;
    logic [31:0]        lifetime_distance;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

  // controller to datapath
  typedef struct packed {
    logic apply;     // update state from the captured word
    logic div_start; // load divider, sel picks the average
    logic div_sel;   // 0 moving, 1 overall
    logic div_step;
    logic div_store;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

[design/tsa_if.sv]
// valid/ready channel interface
interface tsa_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/tsa_ctrl.sv]
// controller sequencing state update, two divisions and the result word
module tsa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tsa_pkg::dp_cmd_t cmd_o,
  input  tsa_pkg::dp_sts_t sts_i
);
  import tsa_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StApply = 3'd1;
  localparam logic [2:0] StDivM  = 3'd2;
  localparam logic [2:0] StDivO  = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;
  localparam logic [2:0] StLoad  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = StApply;
      end
      StApply: begin
        cmd_o.apply     = 1'b1;
        state_d         = StLoad;
      end
      StLoad: begin
        // divider loads from the statistics as updated by the apply cycle
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b0;
        state_d         = StDivM;
      end
      StDivM: begin
        // step until the last quotient bit, then load the overall pass
        cmd_o.div_sel  = 1'b0;
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.div_store = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b1;
          state_d         = StDivO;
        end
      end
      StDivO: begin
        cmd_o.div_sel  = 1'b1;
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.div_store = 1'b1;
          state_d         = StOut;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

[design/tsa_dp.sv]
// datapath: statistics registers, config registers and a radix-2 divider
module tsa_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  tsa_pkg::in_item_t  in_data_i,
  input  logic               cfg_fire_i,
  input  tsa_pkg::cfg_item_t cfg_data_i,
  input  tsa_pkg::dp_cmd_t   cmd_i,
  output tsa_pkg::dp_sts_t   sts_o,
  output tsa_pkg::out_item_t out_o
);
  import tsa_pkg::*;

  localparam int unsigned NumW = 38; // 36 * 2^32 fits in 38 bits
  localparam int unsigned DenW = 33;
  localparam int unsigned CntW = 6;

  logic        count_total_q;
  logic [7:0]  climb_step_q;
  logic [9:0]  jump_limit_q;
  in_item_t    item_q;

  logic               paused_q;
  logic [15:0]        prev_odo_q, pend_q;
  logic signed [15:0] ref_alt_q, alt_high_q, alt_low_q;
  logic [31:0]        dist_q, move_q, still_q, asc_q, desc_q, day_q, total_q;
  logic [7:0]         peak_q;
  logic [15:0]        avg_m_q, avg_o_q;

  // tick arithmetic
  logic [15:0]        delta;
  logic signed [16:0] dalt;
  logic [16:0]        mag;
  logic               do_clear;
  assign delta    = item_q.odometer_m - prev_odo_q;
  assign dalt     = 17'(item_q.altitude) - 17'(ref_alt_q);
  assign mag      = dalt[16] ? 17'(-dalt) : 17'(dalt);
  assign do_clear = (item_q.kind == KIND_CLEAR) ||
                    ((item_q.kind == KIND_NEW_TRIP) && (dist_q != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_total_q <= 1'b1;
      climb_step_q  <= ClimbStepRst;
      jump_limit_q  <= JumpLimitRst;
    end else if (cfg_fire_i) begin
      unique case (cfg_idx_e'(cfg_data_i.index))
        CFG_COUNT_TOTAL: count_total_q <= cfg_data_i.data[0];
        CFG_CLIMB_STEP:  climb_step_q  <= cfg_data_i.data[7:0];
        CFG_JUMP_LIMIT:  jump_limit_q  <= cfg_data_i.data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) item_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paused_q <= 1'b0; prev_odo_q <= '0; pend_q <= '0; ref_alt_q <= '0;
      dist_q <= '0; peak_q <= '0; move_q <= '0; still_q <= '0;
      alt_high_q <= '0; alt_low_q <= '0; asc_q <= '0; desc_q <= '0;
      day_q <= '0; total_q <= '0;
    end else if (cmd_i.apply) begin
      if (do_clear) begin
        paused_q <= 1'b0; dist_q <= '0; peak_q <= '0; move_q <= '0;
        still_q <= '0; asc_q <= '0; desc_q <= '0;
        alt_high_q <= item_q.altitude; alt_low_q <= item_q.altitude;
        ref_alt_q <= item_q.altitude;
      end else begin
        unique case (kind_e'(item_q.kind))
          KIND_TICK: begin
            prev_odo_q <= item_q.odometer_m;
            if (!paused_q) begin
              if (count_total_q) total_q <= total_q + 32'(delta);
              day_q  <= day_q + 32'(delta);
              dist_q <= dist_q + 32'(delta);
              if (item_q.speed_kmh > peak_q) peak_q <= item_q.speed_kmh;
              if (item_q.speed_kmh != '0) begin
                if (move_q != '0) still_q <= still_q + 32'(pend_q);
                move_q <= move_q + 32'd1;
                pend_q <= '0;
              end else begin
                pend_q <= pend_q + 16'd1;
              end
              if (item_q.altitude > alt_high_q) alt_high_q <= item_q.altitude;
              if (item_q.altitude < alt_low_q) alt_low_q <= item_q.altitude;
              if (mag < 17'(jump_limit_q)) begin
                if (mag > 17'(climb_step_q)) begin
                  if (!dalt[16]) asc_q <= asc_q + 32'(mag);
                  else desc_q <= desc_q + 32'(mag);
                  ref_alt_q <= item_q.altitude;
                end
              end else begin
                ref_alt_q <= item_q.altitude;
              end
            end
          end
          KIND_NEW_TRIP, KIND_PAUSE_OFF: paused_q <= 1'b0;
          KIND_PAUSE_ON:  paused_q <= 1'b1;
          KIND_RESET_DAY: day_q <= '0;
          KIND_SET_TOTAL: total_q <= 32'(item_q.set_km) * 32'(MetresPerKm);
          default: ;
        endcase
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW:0]   rem_sh, rem_sub;
  logic [DenW-1:0] den_new;
  logic [15:0]     quo_sat;

  assign den_new = cmd_i.div_sel ? (33'(move_q) + 33'(still_q)) : 33'(move_q);
  assign rem_sh  = {rem_q[DenW-1:0], num_q[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign sts_o.div_last = (cnt_q == CntW'(NumW - 1));
  // quotient as it stands after the final step
  assign quo_sat = (den_q == '0) ? 16'd0 :
                   ((num_q[NumW-2:0] >> 0) != '0 && |num_q[NumW-2:15]) ? 16'hFFFF :
                   {num_q[14:0], !rem_sub[DenW]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q <= NumW'(dist_q) * NumW'(AvgScale);
      den_q <= den_new;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NumW-2:0], !rem_sub[DenW]};
      rem_q <= rem_sub[DenW] ? rem_sh : rem_sub;
      cnt_q <= cnt_q + CntW'(1);
    end
    if (cmd_i.div_store) begin
      if (cmd_i.div_sel && !cmd_i.div_start) avg_o_q <= quo_sat;
      else avg_m_q <= quo_sat;
    end
  end

  assign out_o.trip_distance     = dist_q;
  assign out_o.top_speed         = peak_q;
  assign out_o.moving_time       = move_q;
  assign out_o.standing_time     = still_q;
  assign out_o.highest_alt       = alt_high_q;
  assign out_o.lowest_alt        = alt_low_q;
  assign out_o.climbed           = asc_q;
  assign out_o.dropped           = desc_q;
  assign out_o.avg_moving        = avg_m_q;
  assign out_o.avg_overall       = avg_o_q;
  assign out_o.day_distance      = day_q;
  assign out_o.lifetime_distance = total_q;
endmodule

[design/trip_statistics_accumulator.sv]
// top level of the trip statistics accumulator
//
//  channel  dir  payload            handshake
//  in       in   tsa_pkg::in_item_t  in_valid/in_ready
//  out      out  tsa_pkg::out_item_t out_valid/out_ready
//  cfg      in   tsa_pkg::cfg_item_t cfg_valid/cfg_ready
//
// a word goes through the accepting cycle, the apply state, the divider load,
// two 38-step passes of the shared one-bit-per-cycle divider for the two
// averages, and the output state.
// async reset clears all statistics but the two averages; no clearing pass.
// a new word is taken only after the result word has left;
// a stalled output holds its word. config writes are always taken.
module trip_statistics_accumulator (
  input logic clk_i,
  input logic rst_ni,
  tsa_if.sink   in_i,
  tsa_if.source out_o,
  tsa_if.sink   cfg_i
);
  import tsa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  tsa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tsa_dp u_dp (
    .clk_i, .rst_ni,
    .in_fire_i  (in_i.valid && in_ready),
    .in_data_i  (in_i.data),
    .cfg_fire_i (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_o      (out_o.data)
  );
endmodule

[bench/tsa_trip_checker.sv]
// checker that predicts trip statistics words and compares them with the block's output
module tsa_trip_checker (
  input  logic    clk_i,
  input  logic    rst_ni,
  tsa_if.sink     in_mon,
  tsa_if.sink     out_mon,
  tsa_if.sink     cfg_mon,
  output int      fail_count,
  output int      pending_words
);
  import tsa_pkg::*;

  // predictor state
  logic        count_total_q;
  logic [7:0]  climb_step_q;
  logic [9:0]  jump_limit_q;
  logic        paused_q;
  logic [15:0] prev_odo_q;
  logic [15:0] pending_still_q;
  logic signed [15:0] ref_alt_q;
  logic [31:0] trip_m_q;
  logic [7:0]  peak_kmh_q;
  logic [31:0] moving_s_q;
  logic [31:0] still_s_q;
  logic signed [15:0] alt_hi_q;
  logic signed [15:0] alt_lo_q;
  logic [31:0] climb_m_q;
  logic [31:0] drop_m_q;
  logic [31:0] day_m_q;
  logic [31:0] total_m_q;

  out_item_t expected_words[$];

  assign pending_words = expected_words.size();

  function automatic logic [15:0] avg_speed(logic [32:0] secs, logic [31:0] metres);
    logic [63:0] q;
    if (secs == 0) return 16'd0;
    q = (64'(metres) * 64'(AvgScale)) / 64'(secs);
    return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  task automatic restart_trip(logic signed [15:0] alt);
    paused_q   = 1'b0;
    trip_m_q   = '0;
    peak_kmh_q = '0;
    moving_s_q = '0;
    still_s_q  = '0;
    alt_hi_q   = alt;
    alt_lo_q   = alt;
    climb_m_q  = '0;
    drop_m_q   = '0;
    ref_alt_q  = alt;
  endtask

  task automatic apply_tick(in_item_t w);
    logic [15:0] delta;
    int          dalt;
    int          mag;
    if (paused_q) begin
      prev_odo_q = w.odometer_m;
      return;
    end
    delta = w.odometer_m - prev_odo_q;
    if (count_total_q) total_m_q += 32'(delta);
    day_m_q  += 32'(delta);
    trip_m_q += 32'(delta);
    if (w.speed_kmh > peak_kmh_q) peak_kmh_q = w.speed_kmh;
    if (w.speed_kmh != 0) begin
      if (moving_s_q != 0) still_s_q += 32'(pending_still_q);
      moving_s_q++;
      pending_still_q = '0;
    end else begin
      pending_still_q = pending_still_q + 16'd1;
    end
    prev_odo_q = w.odometer_m;
    if (w.altitude > alt_hi_q) alt_hi_q = w.altitude;
    if (w.altitude < alt_lo_q) alt_lo_q = w.altitude;
    dalt = int'(w.altitude) - int'(ref_alt_q);
    mag  = (dalt < 0) ? -dalt : dalt;
    if (mag < int'(jump_limit_q)) begin
      if (mag > int'(climb_step_q)) begin
        if (dalt > 0) climb_m_q += 32'(mag);
        else drop_m_q += 32'(mag);
        ref_alt_q = w.altitude;
      end
    end else begin
      ref_alt_q = w.altitude;
    end
  endtask

  function automatic out_item_t snapshot();
    out_item_t r;
    r.trip_distance     = trip_m_q;
    r.top_speed         = peak_kmh_q;
    r.moving_time       = moving_s_q;
    r.standing_time     = still_s_q;
    r.highest_alt       = alt_hi_q;
    r.lowest_alt        = alt_lo_q;
    r.climbed           = climb_m_q;
    r.dropped           = drop_m_q;
    r.avg_moving        = avg_speed(33'(moving_s_q), trip_m_q);
    r.avg_overall       = avg_speed(33'(moving_s_q) + 33'(still_s_q), trip_m_q);
    r.day_distance      = day_m_q;
    r.lifetime_distance = total_m_q;
    return r;
  endfunction

  task automatic predict_word(in_item_t w);
    case (kind_e'(w.kind))
      KIND_TICK:      apply_tick(w);
      KIND_CLEAR:     restart_trip(w.altitude);
      KIND_NEW_TRIP: begin
        paused_q = 1'b0;
        if (trip_m_q != 0) restart_trip(w.altitude);
      end
      KIND_PAUSE_ON:  paused_q = 1'b1;
      KIND_PAUSE_OFF: paused_q = 1'b0;
      KIND_RESET_DAY: day_m_q = '0;
      KIND_SET_TOTAL: total_m_q = 32'(w.set_km) * 32'(MetresPerKm);
      default: ;
    endcase
    expected_words.push_back(snapshot());
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic compare_word(out_item_t act);
    out_item_t e;
    if (expected_words.size() == 0) begin
      $error("result word with no expectation waiting");
      fail_count++;
      return;
    end
    e = expected_words.pop_front();
    check_field("trip_distance", e.trip_distance, act.trip_distance);
    check_field("top_speed", 32'(e.top_speed), 32'(act.top_speed));
    check_field("moving_time", e.moving_time, act.moving_time);
    check_field("standing_time", e.standing_time, act.standing_time);
    check_field("highest_alt", 32'(e.highest_alt), 32'(act.highest_alt));
    check_field("lowest_alt", 32'(e.lowest_alt), 32'(act.lowest_alt));
    check_field("climbed", e.climbed, act.climbed);
    check_field("dropped", e.dropped, act.dropped);
    check_field("avg_moving", 32'(e.avg_moving), 32'(act.avg_moving));
    check_field("avg_overall", 32'(e.avg_overall), 32'(act.avg_overall));
    check_field("day_distance", e.day_distance, act.day_distance);
    check_field("lifetime_distance", e.lifetime_distance, act.lifetime_distance);
  endtask

  initial fail_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_total_q   = 1'b1;
      climb_step_q    = ClimbStepRst;
      jump_limit_q    = JumpLimitRst;
      paused_q        = 1'b0;
      prev_odo_q      = '0;
      pending_still_q = '0;
      ref_alt_q       = '0;
      trip_m_q        = '0;
      peak_kmh_q      = '0;
      moving_s_q      = '0;
      still_s_q       = '0;
      alt_hi_q        = '0;
      alt_lo_q        = '0;
      climb_m_q       = '0;
      drop_m_q        = '0;
      day_m_q         = '0;
      total_m_q       = '0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_e'(cfg_mon.data.index))
          CFG_COUNT_TOTAL: count_total_q = cfg_mon.data.data[0];
          CFG_CLIMB_STEP:  climb_step_q  = cfg_mon.data.data[7:0];
          CFG_JUMP_LIMIT:  jump_limit_q  = cfg_mon.data.data[9:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) compare_word(out_mon.data);
      if (in_mon.valid && in_mon.ready) predict_word(in_mon.data);
    end
  end

  // leftover expectations are counted by the top at the end of the run
endmodule

[bench/tb_trip_statistics_accumulator.sv]
// testbench top: stimulus, idling phases and verdict for the trip statistics accumulator
module tb_trip_statistics_accumulator;
  import tsa_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending_words;
  int   send_idle_pct;
  int   recv_idle_pct;

  tsa_if #(.payload_t(in_item_t))  in_ch ();
  tsa_if #(.payload_t(out_item_t)) out_ch ();
  tsa_if #(.payload_t(cfg_item_t)) cfg_ch ();

  trip_statistics_accumulator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  tsa_trip_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_ch.sink),
    .out_mon       (out_ch.sink),
    .cfg_mon       (cfg_ch.sink),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver stalls at random, decided at each falling edge
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays up after a word until the next word or an idle cycle replaces it
  task automatic send_word(in_item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_words();
    in_ch.valid <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.data  <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic in_item_t make_word(kind_e k, logic [15:0] odo, logic [7:0] kmh,
                                         logic [15:0] alt, logic [15:0] km);
    in_item_t w;
    w.kind       = k;
    w.odometer_m = odo;
    w.speed_kmh  = kmh;
    w.altitude   = alt;
    w.set_km     = km;
    return w;
  endfunction

  // rides: mostly ticks with plausible motion, with commands mixed in
  task automatic ride(int n_words, int style);
    logic [15:0] odo;
    logic [15:0] alt;
    int          r;
    kind_e       k;
    odo = 16'($urandom);
    alt = 16'($urandom_range(2000));
    for (int i = 0; i < n_words; i++) begin
      r = $urandom_range(99);
      if (style == 0 || r < 80) begin
        k = KIND_TICK;
        if ($urandom_range(9) == 0) odo = 16'($urandom);
        else odo += 16'($urandom_range(15));
        if ($urandom_range(19) == 0) alt = 16'($urandom);
        else alt += 16'($signed($urandom_range(40)) - 20);
      end else begin
        k = kind_e'(3'($urandom_range(7)));
      end
      send_word(make_word(k, odo,
                ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom),
                (style == 2) ? 16'($urandom) : alt, 16'($urandom)));
    end
  endtask

  task automatic random_setting();
    write_reg(CFG_COUNT_TOTAL, 16'($urandom));
    write_reg(CFG_CLIMB_STEP, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(10)));
    write_reg(CFG_JUMP_LIMIT, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(200)));
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 53;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: every command and the field extremes
    send_word(make_word(KIND_TICK, 16'd0, 8'd0, 16'd0, 16'd0));
    send_word(make_word(KIND_TICK, 16'hFFFF, 8'd0, 16'h7FFF, 16'd0));
    send_word(make_word(KIND_TICK, 16'h0005, 8'd255, 16'h8000, 16'd0));
    send_word(make_word(KIND_TICK, 16'h0010, 8'd1, 16'h8010, 16'd0));
    send_word(make_word(KIND_TICK, 16'h0020, 8'd0, 16'h8000, 16'd0));
    send_word(make_word(KIND_TICK, 16'h0030, 8'd7, 16'h8005, 16'd0));
    send_word(make_word(KIND_PAUSE_ON, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_word(make_word(KIND_TICK, 16'h1000, 8'd99, 16'h0100, 16'd0));
    send_word(make_word(KIND_PAUSE_OFF, 16'd0, 8'd0, 16'd0, 16'd0));
    send_word(make_word(KIND_TICK, 16'h1010, 8'd20, 16'h8031, 16'd0));
    send_word(make_word(KIND_SET_TOTAL, 16'd0, 8'd0, 16'd0, 16'hFFFF));
    send_word(make_word(KIND_RESET_DAY, 16'd0, 8'd0, 16'd0, 16'd0));
    send_word(make_word(KIND_NONE, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_word(make_word(KIND_NEW_TRIP, 16'd0, 8'd0, 16'h0064, 16'd0));
    send_word(make_word(KIND_NEW_TRIP, 16'd0, 8'd0, 16'h0200, 16'd0));
    send_word(make_word(KIND_TICK, 16'h1010, 8'd0, 16'h0064, 16'd0));
    send_word(make_word(KIND_CLEAR, 16'd0, 8'd0, 16'h8000, 16'd0));
    send_word(make_word(KIND_SET_TOTAL, 16'd0, 8'd0, 16'd0, 16'd0));
    // pause until every word has come back
    drain_words();

    // extreme settings
    write_reg(CFG_COUNT_TOTAL, 16'd0);
    write_reg(CFG_CLIMB_STEP, 16'd0);
    write_reg(CFG_JUMP_LIMIT, 16'd1023);
    ride(60, 2);
    drain_words();
    write_reg(CFG_COUNT_TOTAL, 16'hFFFF);
    write_reg(CFG_CLIMB_STEP, 16'd255);
    write_reg(CFG_JUMP_LIMIT, 16'd0);
    ride(60, 1);
    drain_words();
    write_reg(CFG_JUMP_LIMIT, 16'd1);
    write_reg(CFG_CLIMB_STEP, 16'd0);
    ride(40, 0);

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 29 : (p == 1) ? 53 : 0;
      recv_idle_pct = (p == 0) ? 53 : (p == 1) ? 29 : 0;
      for (int s = 0; s < 4; s++) begin
        drain_words();
        random_setting();
        ride(106, (s == 3) ? 2 : 1);
      end
    end

    drain_words();
    if (fail_count == 0 && pending_words == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end
endmodule
